/* hdl/priority_order_and_average_wait_top_macros.svh */
// Assertion macros for the priority order block.
// Included by the modules that carry concurrent checks; no dependencies.
`ifndef PRIORITY_ORDER_AND_AVERAGE_WAIT_TOP_MACROS_SVH
`define PRIORITY_ORDER_AND_AVERAGE_WAIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define POW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pow assertion failed");
`define POW_ASSERT_SEQ(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pow sequence assertion failed");
`else
`define POW_ASSERT(lbl, clk, rst_n, prop)
`define POW_ASSERT_SEQ(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/pow_pkg.sv */
// Shared types and widths for the priority order block.
// No dependencies.
package pow_pkg;
    localparam int IdW    = 8;
    localparam int BurstW = 16;
    localparam int PrioW  = 8;
    localparam int PrefW  = 22;
    localparam int TotW   = 28;
    localparam int FracW  = 16;
    localparam int DivW   = TotW + FracW;
    localparam int AvgW   = 38;

    typedef struct packed {
        logic [IdW-1:0]    id;
        logic [BurstW-1:0] burst;
        logic [PrioW-1:0]  prio;
    } t_rec;

    localparam int RecW = $bits(t_rec);
endpackage

/* hdl/priority_order_and_average_wait_top.sv */
// Priority order and average wait: collects a batch of process records, one
// transfer per cycle while o_stall is low, sorts them by priority number
// with an exchange sort in a single record RAM, then emits them in order;
// the last result carries the total and average wait. The sort reads
// through the one read port of the RAM, and the last record waits for the
// average divider before it is emitted.
// Depends on pow_pkg, pow_ram, pow_div and the macros header.
`include "priority_order_and_average_wait_top_macros.svh"
module priority_order_and_average_wait_top #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pow_pkg::IdW-1:0]       i_process_id,
    input  logic [pow_pkg::BurstW-1:0]    i_burst_ms,
    input  logic [pow_pkg::PrioW-1:0]     i_priority_level,
    input  logic                          i_last_record,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pow_pkg::IdW-1:0]       o_out_process_id,
    output logic [pow_pkg::BurstW-1:0]    o_out_burst_ms,
    output logic [pow_pkg::PrioW-1:0]     o_out_priority,
    output logic                          o_end_of_order,
    output logic [pow_pkg::TotW-1:0]      o_total_wait,
    output logic [pow_pkg::AvgW-1:0]      o_average_wait_q16,
    output logic                          o_dropped_flag
);
    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_RECORDS);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_Y_RD   = 4'd1;
    localparam logic [3:0] S_Y_DAT  = 4'd2;
    localparam logic [3:0] S_Z_RD   = 4'd3;
    localparam logic [3:0] S_Z_DAT  = 4'd4;
    localparam logic [3:0] S_E_RD   = 4'd5;
    localparam logic [3:0] S_E_DAT  = 4'd6;
    localparam logic [3:0] S_E_HOLD = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;

    logic [3:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_overflow, n_overflow;
    logic [CW-1:0]               r_y, n_y;
    logic [CW-1:0]               r_z, n_z;
    logic [CW-1:0]               r_k, n_k;
    pow_pkg::t_rec               r_cur, n_cur;
    logic [pow_pkg::PrefW-1:0]   r_prefix, n_prefix;
    logic [pow_pkg::TotW-1:0]    r_total, n_total;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_end, n_out_end;
    pow_pkg::t_rec               r_out_rec, n_out_rec;
    logic [pow_pkg::TotW-1:0]    r_out_total, n_out_total;
    logic [pow_pkg::AvgW-1:0]    r_out_avg, n_out_avg;
    logic                        r_out_drop, n_out_drop;

    logic                        in_take, out_take;
    logic                        we;
    logic [AW-1:0]               waddr, raddr;
    pow_pkg::t_rec               wdata, rdata, in_rec;
    logic [pow_pkg::RecW-1:0]    rdata_raw;
    logic                        div_start, div_done;
    logic [pow_pkg::DivW-1:0]    div_quo;

    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign in_rec   = '{id: i_process_id, burst: i_burst_ms, prio: i_priority_level};
    assign rdata    = pow_pkg::t_rec'(rdata_raw);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_y         = r_y;
        n_z         = r_z;
        n_k         = r_k;
        n_cur       = r_cur;
        n_prefix    = r_prefix;
        n_total     = r_total;
        n_out_valid = r_out_valid && !out_take;
        n_out_end   = r_out_end;
        n_out_rec   = r_out_rec;
        n_out_total = r_out_total;
        n_out_avg   = r_out_avg;
        n_out_drop  = r_out_drop;
        we          = 1'b0;
        waddr       = r_count[AW-1:0];
        wdata       = in_rec;
        raddr       = r_y[AW-1:0];
        div_start   = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (in_take) begin
                    if (r_count < MaxCnt) begin
                        we      = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_last_record) begin
                        n_y     = '0;
                        n_state = S_Y_RD;
                    end
                end
            end
            S_Y_RD: begin
                if (r_y == r_count) begin
                    n_k      = '0;
                    n_prefix = '0;
                    n_total  = '0;
                    n_state  = S_E_RD;
                end else begin
                    n_z     = CW'(r_y + 1'b1);
                    n_state = S_Y_DAT;
                end
            end
            S_Y_DAT: begin
                n_cur   = rdata;
                n_state = S_Z_RD;
            end
            S_Z_RD: begin
                raddr = r_z[AW-1:0];
                if (r_z == r_count) begin
                    we      = 1'b1;
                    waddr   = r_y[AW-1:0];
                    wdata   = r_cur;
                    n_y     = CW'(r_y + 1'b1);
                    n_state = S_Y_RD;
                end else begin
                    n_state = S_Z_DAT;
                end
            end
            S_Z_DAT: begin
                if (r_cur.prio > rdata.prio) begin
                    we    = 1'b1;
                    waddr = r_z[AW-1:0];
                    wdata = r_cur;
                    n_cur = rdata;
                end
                n_z     = CW'(r_z + 1'b1);
                n_state = S_Z_RD;
            end
            S_E_RD: begin
                raddr   = r_k[AW-1:0];
                n_state = S_E_DAT;
            end
            S_E_DAT: begin
                n_total   = r_total + pow_pkg::TotW'(r_prefix);
                n_prefix  = r_prefix + pow_pkg::PrefW'(rdata.burst);
                n_out_rec = rdata;
                if (CW'(r_k + 1'b1) == r_count) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_out_valid = 1'b1;
                    n_out_end   = 1'b0;
                    n_out_total = '0;
                    n_out_avg   = '0;
                    n_out_drop  = 1'b0;
                    n_state     = S_E_HOLD;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_out_valid = 1'b1;
                    n_out_end   = 1'b1;
                    n_out_total = r_total;
                    n_out_avg   = div_quo[pow_pkg::AvgW-1:0];
                    n_out_drop  = r_overflow;
                    n_state     = S_E_HOLD;
                end
            end
            S_E_HOLD: begin
                if (!r_out_valid || out_take) begin
                    if (r_out_end) begin
                        n_count    = '0;
                        n_overflow = 1'b0;
                        n_out_end  = 1'b0;
                        n_state    = S_LOAD;
                    end else begin
                        n_k     = CW'(r_k + 1'b1);
                        n_state = S_E_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_end   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
            r_out_end   <= n_out_end;
        end
        r_y         <= n_y;
        r_z         <= n_z;
        r_k         <= n_k;
        r_cur       <= n_cur;
        r_prefix    <= n_prefix;
        r_total     <= n_total;
        r_out_rec   <= n_out_rec;
        r_out_total <= n_out_total;
        r_out_avg   <= n_out_avg;
        r_out_drop  <= n_out_drop;
    end

    pow_ram #(
        .Width (pow_pkg::RecW),
        .Depth (MAX_RECORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    pow_div #(
        .DivisorW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_total, pow_pkg::FracW'(0)}),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_stall            = (r_state != S_LOAD);
    assign o_valid            = r_out_valid;
    assign o_out_process_id   = r_out_rec.id;
    assign o_out_burst_ms     = r_out_rec.burst;
    assign o_out_priority     = r_out_rec.prio;
    assign o_end_of_order     = r_out_end;
    assign o_total_wait       = r_out_total;
    assign o_average_wait_q16 = r_out_avg;
    assign o_dropped_flag     = r_out_drop;

    `POW_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= MaxCnt)
    `POW_ASSERT(a_overflow_full, i_clk, i_rst_n, !r_overflow || (r_count == MaxCnt))
    `POW_ASSERT_SEQ(a_last_to_load, i_clk, i_rst_n, out_take && r_out_end, r_state == S_LOAD)
    `POW_ASSERT_SEQ(a_div_to_out, i_clk, i_rst_n, (r_state == S_DIV) && div_done, r_out_valid && r_out_end)
endmodule

/* hdl/pow_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pow_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/pow_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on pow_pkg for the dividend width.
module pow_div #(
    parameter int DivisorW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pow_pkg::DivW-1:0]   i_dividend,
    input  logic [DivisorW-1:0]        i_divisor,
    output logic                       o_done,
    output logic [pow_pkg::DivW-1:0]   o_quotient
);
    localparam int CntW = $clog2(pow_pkg::DivW + 1);

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [CntW-1:0]          r_cnt, n_cnt;
    logic [pow_pkg::DivW-1:0] r_quo, n_quo;
    logic [DivisorW-1:0]      r_rem, n_rem;
    logic [DivisorW-1:0]      r_dvs, n_dvs;
    logic [DivisorW:0]        trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_quo[pow_pkg::DivW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CntW'(pow_pkg::DivW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DivisorW'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[pow_pkg::DivW-2:0], 1'b1};
            end else begin
                n_rem = trial[DivisorW-1:0];
                n_quo = {r_quo[pow_pkg::DivW-2:0], 1'b0};
            end
            n_cnt = CntW'(r_cnt - 1'b1);
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* bench/priority_order_and_average_wait_top_tb.sv */
// Self-checking bench for priority_order_and_average_wait_top: table-driven directed
// batches, then random batches, all scored against an in-bench exchange-sort predictor.
// Depends on pow_pkg and the block's RTL.
module priority_order_and_average_wait_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Cap = 64;
    localparam int NDir = 12;
    localparam longint CycleLimit = 3000000;

    typedef struct {
        logic [pow_pkg::IdW-1:0]    id;
        logic [pow_pkg::BurstW-1:0] burst;
        logic [pow_pkg::PrioW-1:0]  prio;
        logic                       last;
        logic                       typed;
        logic [pow_pkg::IdW-1:0]    e_id;
        logic [pow_pkg::TotW-1:0]   e_tot;
        logic [pow_pkg::AvgW-1:0]   e_avg;
    } t_row;

    typedef struct {
        logic [pow_pkg::IdW-1:0]    id;
        logic [pow_pkg::BurstW-1:0] burst;
        logic [pow_pkg::PrioW-1:0]  prio;
        logic                       eoo;
        logic [pow_pkg::TotW-1:0]   tot;
        logic [pow_pkg::AvgW-1:0]   avg;
        logic                       drop;
    } t_sched;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [pow_pkg::IdW-1:0] i_process_id = '0;
    logic [pow_pkg::BurstW-1:0] i_burst_ms = '0;
    logic [pow_pkg::PrioW-1:0] i_priority_level = '0;
    logic i_last_record = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [pow_pkg::IdW-1:0] o_out_process_id;
    logic [pow_pkg::BurstW-1:0] o_out_burst_ms;
    logic [pow_pkg::PrioW-1:0] o_out_priority;
    logic o_end_of_order;
    logic [pow_pkg::TotW-1:0] o_total_wait;
    logic [pow_pkg::AvgW-1:0] o_average_wait_q16;
    logic o_dropped_flag;

    pow_pkg::t_rec batch_recs[Cap];
    int     batch_len = 0;
    logic   batch_drop = 0;
    t_sched sched_q[$];
    t_row   dir_rows[NDir];
    int     errors = 0;
    longint cycles = 0;

    priority_order_and_average_wait_top #(.MAX_RECORDS(Cap)) DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic schedule_record(input pow_pkg::t_rec r, input logic last);
        pow_pkg::t_rec tmp;
        longint prefix, total, avg;
        t_sched s;
        if (batch_len < Cap) begin
            batch_recs[batch_len] = r;
            batch_len++;
        end else begin
            batch_drop = 1;
        end
        if (!last) return;
        for (int y = 0; y < batch_len; y++)
            for (int z = y + 1; z < batch_len; z++)
                if (batch_recs[y].prio > batch_recs[z].prio) begin
                    tmp = batch_recs[y];
                    batch_recs[y] = batch_recs[z];
                    batch_recs[z] = tmp;
                end
        prefix = 0;
        total = 0;
        for (int k = 0; k < batch_len; k++) begin
            total += prefix;
            prefix += batch_recs[k].burst;
        end
        avg = batch_len ? (total << 16) / batch_len : 0;
        for (int k = 0; k < batch_len; k++) begin
            s.id = batch_recs[k].id;
            s.burst = batch_recs[k].burst;
            s.prio = batch_recs[k].prio;
            s.eoo = (k + 1 == batch_len);
            s.tot = s.eoo ? pow_pkg::TotW'(total) : '0;
            s.avg = s.eoo ? pow_pkg::AvgW'(avg) : '0;
            s.drop = s.eoo & batch_drop;
            sched_q.push_back(s);
        end
        batch_len = 0;
        batch_drop = 0;
    endtask

    task automatic send_record(input pow_pkg::t_rec r, input logic last, input int gap_max);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gap_max)
                                         : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_process_id <= r.id;
        i_burst_ms <= r.burst;
        i_priority_level <= r.prio;
        i_last_record <= last;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        schedule_record(r, last);
    endtask

    task automatic drain_all();
        @(negedge i_clk);
        i_valid <= 0;
        while (sched_q.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 0;
        else if ($urandom_range(0, 19) == 0) i_stall <= 1;
        else if ($urandom_range(0, 1) == 0) i_stall <= ($urandom_range(0, 30) == 0)
                                                      ? i_stall : 0;
    end

    always @(posedge i_clk) begin
        t_sched e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sched_q.size() == 0) begin
                $display("%0t unexpected transfer id %0d", $time, o_out_process_id);
                errors++;
            end else begin
                e = sched_q.pop_front();
                if ({o_out_process_id, o_out_burst_ms, o_out_priority, o_end_of_order,
                     o_total_wait, o_average_wait_q16, o_dropped_flag} !==
                    {e.id, e.burst, e.prio, e.eoo, e.tot, e.avg, e.drop}) begin
                    $display("%0t mismatch exp id %0d b %0d p %0d e %0b t %0d a %0d d %0b",
                             $time, e.id, e.burst, e.prio, e.eoo, e.tot, e.avg, e.drop);
                    $display("%0t          act id %0d b %0d p %0d e %0b t %0d a %0d d %0b",
                             $time, o_out_process_id, o_out_burst_ms, o_out_priority,
                             o_end_of_order, o_total_wait, o_average_wait_q16,
                             o_dropped_flag);
                    errors++;
                end
            end
        end
    end

    task automatic check_typed(input t_row row);
        t_sched e;
        if (!row.typed) return;
        e = sched_q[sched_q.size() - 1];
        if (e.id !== row.e_id || e.tot !== row.e_tot || e.avg !== row.e_avg) begin
            $display("%0t table mismatch exp id %0d t %0d a %0d act id %0d t %0d a %0d",
                     $time, row.e_id, row.e_tot, row.e_avg, e.id, e.tot, e.avg);
            errors++;
        end
    endtask

    initial begin
        pow_pkg::t_rec r;
        int n, mode;
        dir_rows[0]  = '{8'hFF, 16'hFFFF, 8'hFF, 1, 1, 8'hFF, 0, 0};
        dir_rows[1]  = '{8'h00, 16'h0000, 8'h00, 1, 1, 8'h00, 0, 0};
        dir_rows[2]  = '{8'h01, 16'hFFFF, 8'h05, 0, 0, 0, 0, 0};
        dir_rows[3]  = '{8'h02, 16'h0001, 8'h05, 0, 0, 0, 0, 0};
        dir_rows[4]  = '{8'h03, 16'h0010, 8'h00, 1, 0, 0, 0, 0};
        dir_rows[5]  = '{8'hAA, 16'h5555, 8'hFF, 0, 0, 0, 0, 0};
        dir_rows[6]  = '{8'h55, 16'hAAAA, 8'h00, 1, 1, 8'hAA, 28'hAAAA, 38'h5555_0000};
        dir_rows[7]  = '{8'h10, 16'h0003, 8'h80, 0, 0, 0, 0, 0};
        dir_rows[8]  = '{8'h11, 16'h0002, 8'h7F, 0, 0, 0, 0, 0};
        dir_rows[9]  = '{8'h12, 16'h0001, 8'h81, 0, 0, 0, 0, 0};
        dir_rows[10] = '{8'h13, 16'h0004, 8'h7F, 0, 0, 0, 0, 0};
        dir_rows[11] = '{8'h14, 16'h0000, 8'h01, 1, 0, 0, 0, 0};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        foreach (dir_rows[i]) begin
            r = '{dir_rows[i].id, dir_rows[i].burst, dir_rows[i].prio};
            send_record(r, dir_rows[i].last, 20);
            if (dir_rows[i].last) check_typed(dir_rows[i]);
        end
        drain_all();

        for (int k = 0; k < Cap + 2; k++) begin
            r = '{pow_pkg::IdW'($urandom), pow_pkg::BurstW'(16'hFFFF),
                  pow_pkg::PrioW'($urandom_range(0, 3))};
            send_record(r, k == Cap + 1, 3);
        end
        drain_all();

        n = 0;
        while (n < 70) begin
            mode = $urandom_range(0, 9);
            r = '{pow_pkg::IdW'($urandom), pow_pkg::BurstW'($urandom),
                  pow_pkg::PrioW'($urandom)};
            if (mode < 2) r.prio = pow_pkg::PrioW'($urandom_range(0, 3));
            if (mode == 2) r.burst = pow_pkg::BurstW'($urandom_range(0, 3));
            send_record(r, $urandom_range(0, 5) == 0, 40);
            n++;
            if (n == 35) begin
                send_record(r, 1, 0);
                drain_all();
            end
        end
        r = '{8'h7E, 16'h0100, 8'h40};
        send_record(r, 1, 0);
        drain_all();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && sched_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/pow_pkg.sv
hdl/pow_ram.sv
hdl/pow_div.sv
hdl/priority_order_and_average_wait_top.sv
bench/priority_order_and_average_wait_top_tb.sv
